// ----- rtl/ets_pkg.sv -----
package ets_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int LINE_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int KIND_BITS = 5;
  localparam int ERR_BITS = 3;

  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [ERR_BITS-1:0] err_t;
  typedef logic [3:0] kw_t;

  localparam kind_t KIND_EOF     = 5'd0;
  localparam kind_t KIND_LPAREN  = 5'd1;
  localparam kind_t KIND_RPAREN  = 5'd2;
  localparam kind_t KIND_DOT     = 5'd3;
  localparam kind_t KIND_QUEST   = 5'd4;
  localparam kind_t KIND_COLON   = 5'd5;
  localparam kind_t KIND_NUMBER  = 5'd6;
  localparam kind_t KIND_STRING  = 5'd7;
  localparam kind_t KIND_IDENT   = 5'd8;
  localparam kind_t KIND_TRUE    = 5'd9;
  localparam kind_t KIND_FALSE   = 5'd10;
  localparam kind_t KIND_NIL     = 5'd11;
  localparam kind_t KIND_INC     = 5'd12;
  localparam kind_t KIND_PLUS    = 5'd13;
  localparam kind_t KIND_DEC     = 5'd14;
  localparam kind_t KIND_MINUS   = 5'd15;
  localparam kind_t KIND_POW     = 5'd16;
  localparam kind_t KIND_STAR    = 5'd17;
  localparam kind_t KIND_SLASH   = 5'd18;
  localparam kind_t KIND_PERCENT = 5'd19;
  localparam kind_t KIND_EQ      = 5'd20;
  localparam kind_t KIND_GE      = 5'd21;
  localparam kind_t KIND_GT      = 5'd22;
  localparam kind_t KIND_LE      = 5'd23;
  localparam kind_t KIND_LT      = 5'd24;
  localparam kind_t KIND_NE      = 5'd25;
  localparam kind_t KIND_NOT     = 5'd26;
  localparam kind_t KIND_AND     = 5'd27;
  localparam kind_t KIND_OR      = 5'd28;

  localparam err_t ERR_NONE    = 3'd0;
  localparam err_t ERR_EQUALS  = 3'd1;
  localparam err_t ERR_AMP     = 3'd2;
  localparam err_t ERR_BAR     = 3'd3;
  localparam err_t ERR_UNKNOWN = 3'd4;
  localparam err_t ERR_UNTERM  = 3'd5;

  localparam kw_t KW_NONE  = 4'd0;
  localparam kw_t KW_T     = 4'd1;
  localparam kw_t KW_TR    = 4'd2;
  localparam kw_t KW_TRU   = 4'd3;
  localparam kw_t KW_TRUE  = 4'd4;
  localparam kw_t KW_F     = 4'd5;
  localparam kw_t KW_FA    = 4'd6;
  localparam kw_t KW_FAL   = 4'd7;
  localparam kw_t KW_FALS  = 4'd8;
  localparam kw_t KW_FALSE = 4'd9;
  localparam kw_t KW_N     = 4'd10;
  localparam kw_t KW_NI    = 4'd11;
  localparam kw_t KW_NIL   = 4'd12;

endpackage

// ----- rtl/ets_front.sv -----
module ets_front #(
  parameter int POSITION_BITS = ets_pkg::POSITION_BITS_DEFAULT,
  parameter int LINE_BITS = ets_pkg::LINE_BITS_DEFAULT,
  localparam int RW = ets_pkg::KIND_BITS + 2 * POSITION_BITS + 1 + LINE_BITS +
                      ets_pkg::ERR_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_byte,
  input  logic            end_of_source,
  input  logic            q_ready,
  output logic            push,
  output logic [2*RW:0]   push_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_NUMBER = 6'b000010,
    S_STRING = 6'b000100,
    S_IDENT  = 6'b001000,
    S_OPER   = 6'b010000,
    S_ERROR  = 6'b100000
  } mode_t;

  mode_t                    mode, mode_next;
  logic [7:0]               quote, quote_next;
  logic [7:0]               pend, pend_next;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [LINE_BITS-1:0]     tline, tline_next;
  logic [POSITION_BITS:0]   bpos, bpos_next;
  logic [LINE_BITS-1:0]     line, line_next;
  ets_pkg::kw_t             kw, kw_next;

  logic                     accept;
  logic                     is_dig, is_alpha, is_space, is_idc;
  logic [POSITION_BITS:0]   e;
  logic [POSITION_BITS-1:0] p_sat, e_sat;
  logic [LINE_BITS-1:0]     line_inc;

  logic                     idle_emit;
  ets_pkg::kind_t           idle_kind;
  ets_pkg::err_t            idle_err;
  mode_t                    idle_mode;
  logic [POSITION_BITS-1:0] idle_start;
  logic [RW-1:0]            idle_res;

  ets_pkg::kind_t           os_kind, pair_kind, id_kind;
  ets_pkg::err_t            os_err;
  logic [RW-1:0]            os_res;
  ets_pkg::kw_t             kw_step, kw_first;

  logic                     v0, use_idle, two;
  logic [RW-1:0]            res0, eof_res, slot0, slot1;

  function automatic logic [RW-1:0] mk(
    input ets_pkg::kind_t           k,
    input logic [POSITION_BITS-1:0] s,
    input logic [POSITION_BITS:0]   en,
    input logic [LINE_BITS-1:0]     ln,
    input ets_pkg::err_t            er
  );
    return {k, s, en, ln, er};
  endfunction

  assign accept   = in_valid & ~in_stall;
  assign in_stall = ~q_ready;

  assign is_dig   = (char_byte >= "0") && (char_byte <= "9");
  assign is_alpha = ((char_byte >= "a") && (char_byte <= "z")) ||
                    ((char_byte >= "A") && (char_byte <= "Z"));
  assign is_space = (char_byte == " ") || ((char_byte >= 8'd9) && (char_byte <= 8'd13));
  assign is_idc   = is_dig | is_alpha | (char_byte == "_");

  assign e        = bpos + 1'b1;
  assign p_sat    = bpos[POSITION_BITS] ? {POSITION_BITS{1'b1}} : bpos[POSITION_BITS-1:0];
  assign e_sat    = e[POSITION_BITS] ? {POSITION_BITS{1'b1}} : e[POSITION_BITS-1:0];
  assign line_inc = (line == {LINE_BITS{1'b1}}) ? line : line + 1'b1;

  always_comb begin
    idle_emit  = 1'b0;
    idle_kind  = ets_pkg::KIND_EOF;
    idle_err   = ets_pkg::ERR_NONE;
    idle_mode  = S_IDLE;
    idle_start = p_sat;
    case (char_byte)
      "(": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_LPAREN; end
      ")": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_RPAREN; end
      ".": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_DOT; end
      "?": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_QUEST; end
      ":": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_COLON; end
      "/": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_SLASH; end
      "%": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_PERCENT; end
      "^": begin idle_emit = 1'b1; idle_kind = ets_pkg::KIND_POW; end
      "+", "-", "*", "=", ">", "<", "!", "&", "|": idle_mode = S_OPER;
      "\"", "'": idle_mode = S_STRING;
      "_": idle_mode = S_IDENT;
      default: begin
        if (is_dig) begin
          idle_mode = S_NUMBER;
        end else if (is_alpha) begin
          idle_mode = S_IDENT;
        end else if (!is_space) begin
          idle_mode  = S_ERROR;
          idle_emit  = 1'b1;
          idle_err   = ets_pkg::ERR_UNKNOWN;
          idle_start = e_sat;
        end
      end
    endcase
  end

  assign idle_res = mk(idle_kind, idle_start, e, line, idle_err);

  always_comb begin
    os_kind = ets_pkg::KIND_EOF;
    os_err  = ets_pkg::ERR_NONE;
    case (pend)
      "+": os_kind = ets_pkg::KIND_PLUS;
      "-": os_kind = ets_pkg::KIND_MINUS;
      "*": os_kind = ets_pkg::KIND_STAR;
      ">": os_kind = ets_pkg::KIND_GT;
      "<": os_kind = ets_pkg::KIND_LT;
      "!": os_kind = ets_pkg::KIND_NOT;
      "=": os_err = ets_pkg::ERR_EQUALS;
      "&": os_err = ets_pkg::ERR_AMP;
      default: os_err = ets_pkg::ERR_BAR;
    endcase
  end

  assign os_res = (os_err != ets_pkg::ERR_NONE) ?
                  mk(ets_pkg::KIND_EOF, p_sat, bpos, line, os_err) :
                  mk(os_kind, tstart, bpos, line, ets_pkg::ERR_NONE);

  always_comb begin
    pair_kind = ets_pkg::KIND_EOF;
    if (char_byte == pend) begin
      case (pend)
        "+": pair_kind = ets_pkg::KIND_INC;
        "-": pair_kind = ets_pkg::KIND_DEC;
        "*": pair_kind = ets_pkg::KIND_POW;
        "=": pair_kind = ets_pkg::KIND_EQ;
        "&": pair_kind = ets_pkg::KIND_AND;
        "|": pair_kind = ets_pkg::KIND_OR;
        default: pair_kind = ets_pkg::KIND_EOF;
      endcase
    end else if (char_byte == "=") begin
      case (pend)
        ">": pair_kind = ets_pkg::KIND_GE;
        "<": pair_kind = ets_pkg::KIND_LE;
        "!": pair_kind = ets_pkg::KIND_NE;
        default: pair_kind = ets_pkg::KIND_EOF;
      endcase
    end
  end

  always_comb begin
    case (kw)
      ets_pkg::KW_TRUE:  id_kind = ets_pkg::KIND_TRUE;
      ets_pkg::KW_FALSE: id_kind = ets_pkg::KIND_FALSE;
      ets_pkg::KW_NIL:   id_kind = ets_pkg::KIND_NIL;
      default:           id_kind = ets_pkg::KIND_IDENT;
    endcase
  end

  always_comb begin
    kw_step = ets_pkg::KW_NONE;
    case (kw)
      ets_pkg::KW_T:    if (char_byte == "r") kw_step = ets_pkg::KW_TR;
      ets_pkg::KW_TR:   if (char_byte == "u") kw_step = ets_pkg::KW_TRU;
      ets_pkg::KW_TRU:  if (char_byte == "e") kw_step = ets_pkg::KW_TRUE;
      ets_pkg::KW_F:    if (char_byte == "a") kw_step = ets_pkg::KW_FA;
      ets_pkg::KW_FA:   if (char_byte == "l") kw_step = ets_pkg::KW_FAL;
      ets_pkg::KW_FAL:  if (char_byte == "s") kw_step = ets_pkg::KW_FALS;
      ets_pkg::KW_FALS: if (char_byte == "e") kw_step = ets_pkg::KW_FALSE;
      ets_pkg::KW_N:    if (char_byte == "i") kw_step = ets_pkg::KW_NI;
      ets_pkg::KW_NI:   if (char_byte == "l") kw_step = ets_pkg::KW_NIL;
      default:          kw_step = ets_pkg::KW_NONE;
    endcase
    case (char_byte)
      "t":     kw_first = ets_pkg::KW_T;
      "f":     kw_first = ets_pkg::KW_F;
      "n":     kw_first = ets_pkg::KW_N;
      default: kw_first = ets_pkg::KW_NONE;
    endcase
  end

  assign eof_res = mk(ets_pkg::KIND_EOF, p_sat, bpos, line, ets_pkg::ERR_NONE);

  always_comb begin
    mode_next   = mode;
    quote_next  = quote;
    pend_next   = pend;
    tstart_next = tstart;
    tline_next  = tline;
    bpos_next   = bpos;
    line_next   = line;
    kw_next     = kw;
    v0          = 1'b0;
    res0        = eof_res;
    use_idle    = 1'b0;
    if (end_of_source) begin
      case (mode)
        S_NUMBER: begin
          v0   = 1'b1;
          res0 = mk(ets_pkg::KIND_NUMBER, tstart, bpos, line, ets_pkg::ERR_NONE);
        end
        S_IDENT: begin
          v0   = 1'b1;
          res0 = mk(id_kind, tstart, bpos, line, ets_pkg::ERR_NONE);
        end
        S_STRING: begin
          v0   = 1'b1;
          res0 = mk(ets_pkg::KIND_EOF, p_sat, bpos, line, ets_pkg::ERR_UNTERM);
        end
        S_OPER: begin
          v0   = 1'b1;
          res0 = os_res;
        end
        default: v0 = 1'b0;
      endcase
      mode_next   = S_IDLE;
      quote_next  = '0;
      pend_next   = '0;
      tstart_next = '0;
      tline_next  = {{(LINE_BITS-1){1'b0}}, 1'b1};
      bpos_next   = '0;
      line_next   = {{(LINE_BITS-1){1'b0}}, 1'b1};
      kw_next     = ets_pkg::KW_NONE;
    end else begin
      if (!bpos[POSITION_BITS]) begin
        bpos_next = e;
      end
      case (mode)
        S_IDLE: use_idle = 1'b1;
        S_NUMBER: begin
          if (!(is_dig || (char_byte == "."))) begin
            v0       = 1'b1;
            res0     = mk(ets_pkg::KIND_NUMBER, tstart, bpos, line, ets_pkg::ERR_NONE);
            use_idle = 1'b1;
          end
        end
        S_IDENT: begin
          if (is_idc) begin
            kw_next = kw_step;
          end else begin
            v0       = 1'b1;
            res0     = mk(id_kind, tstart, bpos, line, ets_pkg::ERR_NONE);
            use_idle = 1'b1;
          end
        end
        S_STRING: begin
          if (char_byte == quote) begin
            v0        = 1'b1;
            res0      = mk(ets_pkg::KIND_STRING, tstart, e, tline, ets_pkg::ERR_NONE);
            mode_next = S_IDLE;
          end else if (char_byte == 8'd10) begin
            line_next = line_inc;
          end
        end
        S_OPER: begin
          v0 = 1'b1;
          if (pair_kind != ets_pkg::KIND_EOF) begin
            res0      = mk(pair_kind, tstart, e, line, ets_pkg::ERR_NONE);
            mode_next = S_IDLE;
          end else begin
            res0 = os_res;
            if (os_err != ets_pkg::ERR_NONE) begin
              mode_next = S_ERROR;
            end else begin
              use_idle = 1'b1;
            end
          end
        end
        S_ERROR: mode_next = S_ERROR;
        default: mode_next = S_ERROR;
      endcase
      if (use_idle) begin
        mode_next   = idle_mode;
        quote_next  = char_byte;
        pend_next   = char_byte;
        tstart_next = p_sat;
        tline_next  = line;
        kw_next     = kw_first;
        if (char_byte == 8'd10) begin
          line_next = line_inc;
        end
      end
    end
  end

  always_comb begin
    two   = 1'b0;
    slot0 = res0;
    slot1 = eof_res;
    push  = 1'b0;
    if (end_of_source) begin
      two  = v0;
      push = accept;
    end else if (v0 && use_idle && idle_emit) begin
      two   = 1'b1;
      slot1 = idle_res;
      push  = accept;
    end else if (v0) begin
      push = accept;
    end else if (use_idle && idle_emit) begin
      slot0 = idle_res;
      push  = accept;
    end
  end

  assign push_data = {two, slot0, slot1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= S_IDLE;
      quote  <= '0;
      pend   <= '0;
      tstart <= '0;
      tline  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      bpos   <= '0;
      line   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      kw     <= ets_pkg::KW_NONE;
    end else if (accept) begin
      mode   <= mode_next;
      quote  <= quote_next;
      pend   <= pend_next;
      tstart <= tstart_next;
      tline  <= tline_next;
      bpos   <= bpos_next;
      line   <= line_next;
      kw     <= kw_next;
    end
  end

endmodule

// ----- rtl/ets_queue.sv -----
module ets_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ets_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             valid,
  output logic [WIDTH-1:0] data,
  input  logic             pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign ready = (count != CW'(DEPTH));
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ets_back.sv -----
module ets_back #(
  parameter int POSITION_BITS = ets_pkg::POSITION_BITS_DEFAULT,
  parameter int LINE_BITS = ets_pkg::LINE_BITS_DEFAULT,
  localparam int RW = ets_pkg::KIND_BITS + 2 * POSITION_BITS + 1 + LINE_BITS +
                      ets_pkg::ERR_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic [2*RW:0]            q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [4:0]               token_kind,
  output logic [POSITION_BITS-1:0] start_offset,
  output logic [POSITION_BITS:0]   end_offset,
  output logic [LINE_BITS-1:0]     line_number,
  output logic [2:0]               error_code,
  output logic                     last_of_run
);

  logic          sel;
  logic          load, take, two;
  logic [RW-1:0] res;

  assign two   = q_data[2*RW];
  assign load  = ~out_valid | ~out_stall;
  assign take  = load & q_valid;
  assign q_pop = take & (sel | ~two);

  always_ff @(posedge clk) begin
    if (load) begin
      res         <= sel ? q_data[RW-1:0] : q_data[2*RW-1:RW];
      last_of_run <= sel | ~two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= q_valid;
      end
      if (take) begin
        sel <= ~sel & two;
      end
    end
  end

  assign {token_kind, start_offset, end_offset, line_number, error_code} = res;

endmodule

// ----- rtl/expression_token_scanner.sv -----
// An item's first result is written into the queue at the edge that accepts the item, then
// loaded into the output register when not stalled. Throughput: one item per cycle while the
// queue is not full. The output gives one result per cycle when not stalled, so an item with
// two results holds the output for both. A run of such items fills the queue and stalls the
// input until an item's second result loads. An item with no result never enters the queue.
// Reset: synchronous rst clears the scanner state, the queue and the output valid.
module expression_token_scanner #(
  parameter int POSITION_BITS = ets_pkg::POSITION_BITS_DEFAULT,
  parameter int LINE_BITS = ets_pkg::LINE_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = ets_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_source,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [4:0]               token_kind,
  output logic [POSITION_BITS-1:0] start_offset,
  output logic [POSITION_BITS:0]   end_offset,
  output logic [LINE_BITS-1:0]     line_number,
  output logic [2:0]               error_code,
  output logic                     last_of_run
);

  localparam int RW = ets_pkg::KIND_BITS + 2 * POSITION_BITS + 1 + LINE_BITS +
                      ets_pkg::ERR_BITS;

  logic          push, q_ready, q_valid, q_pop;
  logic [2*RW:0] push_data, q_data;

  ets_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_byte(char_byte),
    .end_of_source(end_of_source),
    .q_ready(q_ready),
    .push(push),
    .push_data(push_data)
  );

  ets_queue #(
    .WIDTH(2 * RW + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .ready(q_ready),
    .valid(q_valid),
    .data(q_data),
    .pop(q_pop)
  );

  ets_back #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .start_offset(start_offset),
    .end_offset(end_offset),
    .line_number(line_number),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

endmodule
